[design/rgcd_pkg.sv]
`default_nettype none

package rgcd_pkg;

    // Default word width of the numbers reduced
    localparam int WORD_BITS_DEFAULT = 32;

    // Queue between front and back; depth is a power of two so the pointers wrap
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

    // Classification the front attaches to each queued item
    typedef struct packed {
        logic last;
        logic zero;
    } item_flags_t;

    // Status the back reports for each cycle
    typedef struct packed {
        logic pop;
        logic load;
    } back_stat_t;

endpackage

`default_nettype wire

[design/rgcd_front.sv]
`default_nettype none

module rgcd_front #(
    parameter int WORD_BITS = rgcd_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [WORD_BITS-1:0] value,
    input  wire logic                 last,
    output logic                      q_valid,
    output logic [WORD_BITS-1:0]      q_value,
    output rgcd_pkg::item_flags_t     q_flags,
    input  wire logic                 q_pop
);

    localparam int PTR_W = rgcd_pkg::QUEUE_PTR_W;
    localparam int DEPTH = rgcd_pkg::QUEUE_DEPTH;
    localparam int CNT_W = PTR_W + 1;

    logic [WORD_BITS-1:0]  entry_value_reg [DEPTH];
    rgcd_pkg::item_flags_t entry_flags_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push;
    rgcd_pkg::item_flags_t in_flags;

    assign item_ready = (count_reg != CNT_W'(DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign q_value    = entry_value_reg[rd_ptr_reg];
    assign q_flags    = entry_flags_reg[rd_ptr_reg];

    // Classify on entry: mark the end of a set and a zero operand
    always_comb
    begin
        in_flags.last = last;
        in_flags.zero = (value == '0);
    end

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = q_pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_value_reg[wr_ptr_reg] <= value;
            entry_flags_reg[wr_ptr_reg] <= in_flags;
        end
    end

endmodule

`default_nettype wire

[design/rgcd_back.sv]
`default_nettype none

module rgcd_back #(
    parameter int WORD_BITS = rgcd_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [WORD_BITS-1:0]  q_value,
    input  wire rgcd_pkg::item_flags_t q_flags,
    output rgcd_pkg::back_stat_t       stat,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic [WORD_BITS-1:0]       divisor
);

    localparam int SHIFT_W = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] divisor_reg, divisor_next;
    logic                 a_gt_b;
    logic [WORD_BITS-1:0] big, little, diff, shifted;

    assign result_valid = out_valid_reg;
    assign divisor      = divisor_reg;

    always_comb
    begin
        a_gt_b  = (a_reg > b_reg);
        big     = a_gt_b ? a_reg : b_reg;
        little  = a_gt_b ? b_reg : a_reg;
        diff    = big - little;
        shifted = a_reg << shift_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        shift_next     = shift_reg;
        last_next      = last_reg;
        divisor_next   = divisor_reg;
        out_valid_next = out_valid_reg && !result_ready;
        stat.pop       = 1'b0;
        stat.load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    stat.pop   = 1'b1;
                    a_next     = acc_reg;
                    b_next     = q_value;
                    last_next  = q_flags.last;
                    shift_next = '0;
                    // gcd with zero is the other operand
                    if ((acc_reg == '0) || q_flags.zero)
                    begin
                        a_next     = acc_reg | q_value;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next     = a_reg >> 1;
                    b_next     = b_reg >> 1;
                    shift_next = shift_reg + SHIFT_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else
                begin
                    a_next = little;
                    b_next = diff;
                    if (diff == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    acc_next   = shifted;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || result_ready)
                begin
                    stat.load      = 1'b1;
                    divisor_next   = shifted;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        shift_reg   <= shift_next;
        last_reg    <= last_next;
        divisor_reg <= divisor_next;
    end

endmodule

`default_nettype wire

[design/running_gcd_reduction.sv]
// running_gcd_reduction: reduces sets of unsigned numbers to their gcd.
// Item channel (item_valid/item_ready, value, last): one number per
// transaction; last marks the final number of a set. Result channel
// (result_valid/result_ready, divisor): one transaction per set, carrying
// the gcd of all its numbers, or 0 when they were all zero.
// A two-entry queue parts the input side from the gcd engine, so up to two
// numbers are taken while the engine works or a result waits.
// Each number is popped in the idle state, runs a binary gcd iteration of
// one shift-or-subtract step per cycle, and then has the common factor of
// two restored in the finish state. A number that meets a zero running
// divisor, or is itself zero, skips the iteration and goes straight to
// the finish state.
// Sustained throughput is set by the single shared subtract-and-shift unit.
// Reset clears the queue, the running divisor and result_valid.
// While result_ready is low the result holds in the output register;
// the engine keeps folding numbers of the next set and stalls only when
// the next last number finishes before the pending result is taken.
`default_nettype none

module running_gcd_reduction #(
    parameter int WORD_BITS = rgcd_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [WORD_BITS-1:0] value,
    input  wire logic                 last,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [WORD_BITS-1:0]      divisor
);

    // Queue head toward the engine
    logic                  q_valid;
    logic [WORD_BITS-1:0]  q_value;
    rgcd_pkg::item_flags_t q_flags;
    rgcd_pkg::back_stat_t  stat;

    // Front: accept transactions, classify them, hold them in the queue
    rgcd_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .value     (value),
        .last      (last),
        .q_valid   (q_valid),
        .q_value   (q_value),
        .q_flags   (q_flags),
        .q_pop     (stat.pop)
    );

    // Back: fold each number into the running divisor, drive results
    rgcd_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_value     (q_value),
        .q_flags     (q_flags),
        .stat        (stat),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .divisor     (divisor)
    );

`ifndef NO_ASSERTIONS
    // The engine never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> q_valid)
        else $error("engine popped an empty queue");

    // A result never overwrites one that has not been taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat.load |-> (!result_valid || result_ready))
        else $error("pending result overwritten");

    // A new result appears only after the engine loaded one
    a_rise_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stat.load))
        else $error("result_valid rose without a load");
`endif

endmodule

`default_nettype wire

[tb/gcd_set_checker.sv]
module gcd_set_checker #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire logic         item_ready,
    input  wire logic [W-1:0] value,
    input  wire logic         last,
    input  wire logic         result_valid,
    input  wire logic         result_ready,
    input  wire logic [W-1:0] divisor,
    output int                fail_count,
    output int                sets_waiting,
    output int                numbers_seen,
    output int                sets_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [W-1:0] set_divisor;
    logic [W-1:0] expected_divisors[$];

    // Stein gcd, with gcd(0, x) = x
    function automatic logic [W-1:0] stein_gcd(input logic [W-1:0] a, input logic [W-1:0] b);
        int unsigned twos = 0;
        logic [W-1:0] t;
        if (a == '0)
            return b;
        if (b == '0)
            return a;
        while (!(a[0] | b[0]))
        begin
            a = a >> 1;
            b = b >> 1;
            twos++;
        end
        while (!a[0])
            a = a >> 1;
        do
        begin
            while (!b[0])
                b = b >> 1;
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end while (b != '0);
        return a << twos;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [W-1:0] want;
        if (!rst_n)
        begin
            set_divisor = '0;
            expected_divisors.delete();
            fail_count   <= 0;
            sets_waiting <= 0;
            numbers_seen <= 0;
            sets_checked <= 0;
        end
        else
        begin
            // Results first: a result can never belong to a number taken at the same edge
            if (result_valid && result_ready)
            begin
                if (expected_divisors.size() == 0)
                begin
                    $error("divisor: unexpected result %0h with no set pending", divisor);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_divisors.pop_front();
                    sets_checked <= sets_checked + 1;
                    if (divisor !== want)
                    begin
                        $error("divisor mismatch: expected %0h, actual %0h", want, divisor);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                numbers_seen <= numbers_seen + 1;
                set_divisor = stein_gcd(set_divisor, value);
                if (last)
                begin
                    expected_divisors.push_back(set_divisor);
                    set_divisor = '0;
                end
            end
            sets_waiting <= expected_divisors.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = rgcd_pkg::WORD_BITS_DEFAULT;
    // Cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // Settle time after the last result, well above one worst-case fold
    localparam int TAIL_CYCLES = 200;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    logic [W-1:0] value;
    logic         last;
    logic         result_valid;
    logic         result_ready;
    logic [W-1:0] divisor;

    int fail_count;
    int sets_waiting;
    int numbers_seen;
    int sets_checked;

    // Idle enables for each side; both are cleared for the final stretch
    bit send_idle_en;
    bit take_idle_en;

    running_gcd_reduction #(
        .WORD_BITS(W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .value(value),
        .last(last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .divisor(divisor)
    );

    gcd_set_checker #(
        .W(W)
    ) gcd_check (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .value(value),
        .last(last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .divisor(divisor),
        .fail_count(fail_count),
        .sets_waiting(sets_waiting),
        .numbers_seen(numbers_seen),
        .sets_checked(sets_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Present one number and hold it until the block takes it. Called at the
    // edge where the previous transaction completed, so item_valid gets only
    // one update per time step: low for a gap, or straight back high.
    task automatic send_number(input logic [W-1:0] v, input logic is_last);
        int gap;
        if (send_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= is_last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every pending set has been reduced
    task automatic drain_sets();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sets_waiting != 0);
    endtask

    // Random sets; most share a common factor so the gcd stays interesting.
    // Stop at a set boundary once the budget is spent.
    task automatic random_sets(input int budget);
        int sent = 0;
        int len;
        int kind;
        int unsigned wbits;
        logic [W-1:0] factor;
        logic [W-1:0] v;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            wbits = $urandom_range(1, W);
            factor = $urandom() >> (W - wbits);
            if (factor == '0)
                factor = 1;
            // Scale the factor by a power of two now and then to test the shift restore
            if (kind < 3 && wbits < W - 4)
                factor = factor << $urandom_range(0, W - wbits - 1);
            for (int i = 0; i < len; i++)
            begin
                if (kind <= 6)
                begin
                    // Multiple of the shared factor, occasionally zero
                    if ($urandom_range(0, 15) == 0)
                        v = '0;
                    else
                        v = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
                end
                else if (kind == 7)
                    v = $urandom();
                else if (kind == 8)
                    v = ($urandom_range(0, 3) == 0) ? W'($urandom()) : '0;
                else
                    v = W'($urandom_range(1, 7)) << $urandom_range(0, W - 3);
                send_number(v, i == len - 1);
                sent++;
            end
        end
    endtask

    // Result side: random back-pressure bursts
    initial
    begin
        int hold;
        hold = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (take_idle_en && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 10);
            result_ready <= (hold == 0);
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("running_gcd_reduction test failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        value        = '0;
        last         = 1'b0;
        send_idle_en = 1'b1;
        take_idle_en = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-number sets: the gcd is the number itself
        send_number(32'h0000_0000, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'h0000_0001, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        // All-zero set reduces to zero
        send_number(32'h0000_0000, 1'b0);
        send_number(32'h0000_0000, 1'b0);
        send_number(32'h0000_0000, 1'b1);
        // Zero against a nonzero number, in both orders
        send_number(32'h0000_0000, 1'b0);
        send_number(32'd36, 1'b1);
        send_number(32'd48, 1'b0);
        send_number(32'h0000_0000, 1'b1);
        // Coprime neighbors at the top of the range
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFFE, 1'b1);
        // Common factors of two: alone in the first set, with an odd factor in the second
        send_number(32'h8000_0000, 1'b0);
        send_number(32'hC000_0000, 1'b1);
        send_number(32'd12, 1'b0);
        send_number(32'd18, 1'b0);
        send_number(32'd30, 1'b1);
        // Largest 32-bit prime against a small prime: long subtract chain
        send_number(32'hFFFF_FFFB, 1'b0);
        send_number(32'd7, 1'b1);
        send_number(32'hAAAA_AAAA, 1'b0);
        send_number(32'h5555_5555, 1'b1);
        send_number(32'h0000_0001, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);

        // Let every directed set come back before random traffic starts
        drain_sets();

        random_sets(500);
        drain_sets();

        // Stretch with no idling on either side
        send_idle_en = 1'b0;
        take_idle_en = 1'b0;
        random_sets(250);

        send_idle_en = 1'b1;
        take_idle_en = 1'b1;
        random_sets(350);

        // Final stretch runs flat out
        send_idle_en = 1'b0;
        take_idle_en = 1'b0;
        random_sets(230);
        item_valid <= 1'b0;

        while (sets_waiting != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Reduced %0d numbers into %0d checked sets, including single, all-zero",
                 numbers_seen, sets_checked);
        $display("and common-factor sets under random idling on both channels.");
        if (fail_count == 0 && sets_waiting == 0)
            $display("running_gcd_reduction test passed");
        else
            $display("running_gcd_reduction test failed");
        $finish;
    end

endmodule

[running_gcd_reduction.f]
design/rgcd_pkg.sv
design/rgcd_front.sv
design/rgcd_back.sv
design/running_gcd_reduction.sv
tb/gcd_set_checker.sv
tb/testbench.sv
